@@ rtl/core/serpentine_scan_position_generator_top_assert.svh @@
// ----------------------------------------------------------------------------
// serpentine scan position generator - assertion macros
// shared concurrent assertion forms, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef SERPENTINE_SCAN_POSITION_GENERATOR_TOP_ASSERT_SVH
`define SERPENTINE_SCAN_POSITION_GENERATOR_TOP_ASSERT_SVH

// check that is switched off while reset is held
`define SSPG_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define SSPG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/sspg_pkg.sv @@
// ----------------------------------------------------------------------------
// sspg_pkg
// types and constants of the serpentine scan position generator
// ----------------------------------------------------------------------------
package sspg_pkg;

    // coordinate width, unsigned q16.16
    localparam int POS_W    = 32;
    // signed width that holds every difference and sum without wrap
    localparam int CALC_W   = POS_W + 4;
    localparam int CFG_IDX_W = 3;

    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [CALC_W-1:0] t_calc;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // sweep heading codes
    typedef enum logic [1:0] {
        HEAD_FORWARD  = 2'd0,
        HEAD_BACKWARD = 2'd1,
        HEAD_MOVING   = 2'd2,
        HEAD_FINISHED = 2'd3
    } t_heading;

    // command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    // register indexes
    localparam t_cfg_idx CFG_COLUMN_MAJOR  = 3'd0;
    localparam t_cfg_idx CFG_STEP_LENGTH   = 3'd1;
    localparam t_cfg_idx CFG_TRACK_OVERLAP = 3'd2;
    localparam t_cfg_idx CFG_HALF_WINDOW_X = 3'd3;
    localparam t_cfg_idx CFG_LIMIT_X       = 3'd4;
    localparam t_cfg_idx CFG_HALF_WINDOW_Y = 3'd5;
    localparam t_cfg_idx CFG_LIMIT_Y       = 3'd6;

    localparam t_pos STEP_LENGTH_RST = 32'h0001_0000;

    // configuration register set
    typedef struct packed {
        logic column_major;
        t_pos step_length;
        t_pos track_overlap;
        t_pos half_window_x;
        t_pos limit_x;
        t_pos half_window_y;
        t_pos limit_y;
    } t_cfg;

    // walker state
    typedef struct packed {
        t_pos     cur_x;
        t_pos     cur_y;
        t_pos     target_track;
        t_heading sweep_dir;
    } t_state;

    // zero extend a coordinate into the signed working width
    function automatic t_calc to_calc(input t_pos v);
        return t_calc'({{(CALC_W-POS_W){1'b0}}, v});
    endfunction

    function automatic t_calc min_calc(input t_calc a, input t_calc b);
        return (a < b) ? a : b;
    endfunction

    // saturate a working value into the unsigned coordinate range
    function automatic t_pos clamp_pos(input t_calc v);
        t_calc top;
        top = to_calc({POS_W{1'b1}});
        if (v < 0) begin
            return '0;
        end else if (v > top) begin
            return {POS_W{1'b1}};
        end else begin
            return v[POS_W-1:0];
        end
    endfunction

endpackage

@@ rtl/core/sspg_if.sv @@
// ----------------------------------------------------------------------------
// sspg channel interfaces
// command, result and register write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface sspg_cmd_if
    import sspg_pkg::*;
();
    logic valid;
    logic ready;
    logic cmd;
    t_pos start_x;
    t_pos start_y;

    modport source (output valid, cmd, start_x, start_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, output ready);
endinterface

interface sspg_res_if
    import sspg_pkg::*;
();
    logic     valid;
    logic     ready;
    t_pos     pos_x;
    t_pos     pos_y;
    t_heading heading;
    logic     moved;

    modport source (output valid, pos_x, pos_y, heading, moved, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, moved, output ready);
endinterface

interface sspg_cfg_if
    import sspg_pkg::*;
();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_pos     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/serpentine_scan_position_generator_top.sv @@
// ----------------------------------------------------------------------------
// serpentine_scan_position_generator_top
// back-and-forth window centre stepper over a map, unsigned q16.16
// ----------------------------------------------------------------------------
// Each command beat (restart or step) yields exactly one result beat in the
// cycle after it is taken. The next walker state is worked out in a single
// combinational pass from the stored state and the command, and is registered
// together with the result, so a new command is taken every cycle for as long
// as the result register is empty or its beat is being taken in that cycle.
// Register writes are always taken and apply to the next command; write them
// while no command is in flight. Register indexes: 0 column_major,
// 1 step_length, 2 track_overlap, 3 half_window_x, 4 limit_x,
// 5 half_window_y, 6 limit_y; index 7 is ignored.
// ----------------------------------------------------------------------------
module serpentine_scan_position_generator_top
    import sspg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    sspg_cfg_if.sink   i_cfg,
    sspg_cmd_if.sink   i_cmd,
    sspg_res_if.source o_res
);

    `include "serpentine_scan_position_generator_top_assert.svh"

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    logic     n_moved;
    logic     r_out_valid;
    logic     r_moved;
    logic     cmd_take;

    // command taken when the result register is free or draining
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_major  <= 1'b0;
            r_cfg.step_length   <= STEP_LENGTH_RST;
            r_cfg.track_overlap <= '0;
            r_cfg.half_window_x <= '0;
            r_cfg.limit_x       <= '0;
            r_cfg.half_window_y <= '0;
            r_cfg.limit_y       <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_COLUMN_MAJOR:  r_cfg.column_major  <= i_cfg.data[0];
                CFG_STEP_LENGTH:   r_cfg.step_length   <= i_cfg.data;
                CFG_TRACK_OVERLAP: r_cfg.track_overlap <= i_cfg.data;
                CFG_HALF_WINDOW_X: r_cfg.half_window_x <= i_cfg.data;
                CFG_LIMIT_X:       r_cfg.limit_x       <= i_cfg.data;
                CFG_HALF_WINDOW_Y: r_cfg.half_window_y <= i_cfg.data;
                CFG_LIMIT_Y:       r_cfg.limit_y       <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // next state logic
    sspg_step u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_cmd     (i_cmd.cmd),
        .i_start_x (i_cmd.start_x),
        .i_start_y (i_cmd.start_y),
        .o_state   (n_state),
        .o_moved   (n_moved)
    );

    // walker state, updated per command beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_x        <= '0;
            r_state.cur_y        <= '0;
            r_state.target_track <= '0;
            r_state.sweep_dir    <= HEAD_FORWARD;
        end else if (cmd_take) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_moved <= n_moved;
        end
    end

    // result position and heading come straight from the walker state, moved from its own register
    assign o_res.valid   = r_out_valid;
    assign o_res.pos_x   = r_state.cur_x;
    assign o_res.pos_y   = r_state.cur_y;
    assign o_res.heading = r_state.sweep_dir;
    assign o_res.moved   = r_moved;

    // assertions
    `SSPG_ASSERT_ALWAYS(a_rst_no_result, !i_rst_n |=> !r_out_valid, "result valid after reset")
    `SSPG_ASSERT_RUN(a_take_gives_result, cmd_take |=> r_out_valid, "command beat lost")
    `SSPG_ASSERT_RUN(a_restart_forward, cmd_take && (i_cmd.cmd == CMD_RESTART) |=> r_state.sweep_dir == HEAD_FORWARD, "restart did not set forward")
    `SSPG_ASSERT_RUN(a_finished_holds, cmd_take && (i_cmd.cmd == CMD_STEP) && (r_state.sweep_dir == HEAD_FINISHED) |=> (r_state.sweep_dir == HEAD_FINISHED) && !r_moved, "step left finished state")
    `SSPG_ASSERT_RUN(a_hold_no_take, !cmd_take |=> $stable(r_state), "state changed without command")

endmodule

@@ rtl/core/sspg_step.sv @@
// ----------------------------------------------------------------------------
// sspg_step
// next walker state for one command: restart load, sweep step, track
// advance and cross-track move, all in one combinational pass
// ----------------------------------------------------------------------------
module sspg_step
    import sspg_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  logic   i_cmd,
    input  t_pos   i_start_x,
    input  t_pos   i_start_y,
    output t_state o_state,
    output logic   o_moved
);

    logic     cm;
    t_calc    p, s, trk;
    t_calc    hw_p, lim_p, hw_s, lim_s, step;
    t_calc    end_p, end_s;
    logic     advance;
    t_heading dir;
    t_pos     p_out, s_out;
    t_state   nxt;

    // map x/y onto primary and secondary axes
    always_comb begin
        cm    = i_cfg.column_major;
        hw_p  = to_calc(cm ? i_cfg.half_window_y : i_cfg.half_window_x);
        lim_p = to_calc(cm ? i_cfg.limit_y : i_cfg.limit_x);
        hw_s  = to_calc(cm ? i_cfg.half_window_x : i_cfg.half_window_y);
        lim_s = to_calc(cm ? i_cfg.limit_x : i_cfg.limit_y);
        step  = to_calc(i_cfg.step_length);
        end_p = lim_p - hw_p;
        end_s = lim_s - hw_s;
    end

    // sweep along the primary axis, advance track at an end, then cross over
    always_comb begin
        p       = to_calc(cm ? i_state.cur_y : i_state.cur_x);
        s       = to_calc(cm ? i_state.cur_x : i_state.cur_y);
        trk     = to_calc(i_state.target_track);
        dir     = i_state.sweep_dir;
        advance = 1'b0;

        case (dir)
            HEAD_FORWARD: begin
                if (p >= end_p) begin
                    advance = 1'b1;
                end else begin
                    p = p + min_calc(step, end_p - p);
                end
            end
            HEAD_BACKWARD: begin
                if (p <= hw_p) begin
                    advance = 1'b1;
                end else begin
                    p = p - min_calc(step, p - hw_p);
                end
            end
            default: begin
            end
        endcase

        // next track, or finished when none is left
        if (advance) begin
            if (trk >= end_s) begin
                dir = HEAD_FINISHED;
            end else begin
                dir = HEAD_MOVING;
                trk = to_calc(clamp_pos(trk + min_calc((hw_s + hw_s) - 
                      to_calc(i_cfg.track_overlap), end_s - trk)));
            end
        end

        // cross-track move, turn round once the track is reached
        if (dir == HEAD_MOVING) begin
            s = to_calc(clamp_pos(s + min_calc(step, trk - s)));
            if (s >= trk) begin
                dir = (p <= hw_p) ? HEAD_FORWARD : HEAD_BACKWARD;
            end
        end

        p_out = clamp_pos(p);
        s_out = clamp_pos(s);
    end

    // restart overrides the sweep result
    always_comb begin
        if (i_cmd == CMD_RESTART) begin
            nxt.cur_x        = i_start_x;
            nxt.cur_y        = i_start_y;
            nxt.target_track = cm ? i_start_x : i_start_y;
            nxt.sweep_dir    = HEAD_FORWARD;
        end else begin
            nxt.cur_x        = cm ? s_out : p_out;
            nxt.cur_y        = cm ? p_out : s_out;
            nxt.target_track = clamp_pos(trk);
            nxt.sweep_dir    = dir;
        end
    end

    assign o_state = nxt;
    assign o_moved = (nxt.cur_x != i_state.cur_x) || (nxt.cur_y != i_state.cur_y);

endmodule
